>>> src/multivalue_logic_vector_resolver_assert.svh
// assertion macros shared by the checker
`ifndef MULTIVALUE_LOGIC_VECTOR_RESOLVER_ASSERT_SVH
`define MULTIVALUE_LOGIC_VECTOR_RESOLVER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MLVR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlvr check failed");

// next-cycle implication, quiet during reset
`define MLVR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlvr check failed");

`endif

>>> src/mlvr_pkg.sv
`timescale 1ns / 1ps
package mlvr_pkg;

	typedef enum logic [2:0] {
		OP_RESOLVE  = 3'd0,
		OP_WAND     = 3'd1,
		OP_WOR      = 3'd2,
		OP_STD      = 3'd3,
		OP_EQUAL    = 3'd4,
		OP_MATCH_X  = 3'd5,
		OP_MATCH_XZ = 3'd6
	} op_t;

	typedef logic [3:0] state_t;

	localparam state_t ST_0  = 4'd0;
	localparam state_t ST_1  = 4'd1;
	localparam state_t ST_X  = 4'd2;
	localparam state_t ST_Z  = 4'd3;
	localparam state_t ST_U  = 4'd4;
	localparam state_t ST_W  = 4'd5;
	localparam state_t ST_L  = 4'd6;
	localparam state_t ST_H  = 4'd7;
	localparam state_t ST_DC = 4'd8;

	localparam int NUM_CODES = 9;
	localparam int WIDTH_W   = 5;

	typedef struct packed {
		op_t  op;
		logic width_eq;
	} ctrl_t;

	// rows a, columns b, in code order 0 1 X Z U W L H -
	localparam state_t IEEE_TBL [0:NUM_CODES-1][0:NUM_CODES-1] = '{
		'{ST_0, ST_X, ST_X, ST_0, ST_U, ST_0, ST_0, ST_0, ST_X},
		'{ST_X, ST_1, ST_X, ST_1, ST_U, ST_1, ST_1, ST_1, ST_X},
		'{ST_X, ST_X, ST_X, ST_X, ST_U, ST_X, ST_X, ST_X, ST_X},
		'{ST_0, ST_1, ST_X, ST_Z, ST_U, ST_W, ST_L, ST_H, ST_X},
		'{ST_U, ST_U, ST_U, ST_U, ST_U, ST_U, ST_U, ST_U, ST_U},
		'{ST_0, ST_1, ST_X, ST_W, ST_U, ST_W, ST_W, ST_W, ST_X},
		'{ST_0, ST_1, ST_X, ST_L, ST_U, ST_W, ST_L, ST_W, ST_X},
		'{ST_0, ST_1, ST_X, ST_H, ST_U, ST_W, ST_W, ST_H, ST_X},
		'{ST_X, ST_X, ST_X, ST_X, ST_U, ST_X, ST_X, ST_X, ST_X}
	};

	function automatic state_t resolve_lane(op_t op, state_t a, state_t b);
		state_t r;
		r = a;
		case (op)
			OP_RESOLVE: begin
				if (a == b) r = a;
				else if (a == ST_Z) r = b;
				else if (b == ST_Z) r = a;
				else r = ST_X;
			end
			OP_WAND: begin
				if (a == ST_0 || b == ST_0) r = ST_0;
				else if (a == ST_Z) r = b;
				else if (b == ST_Z) r = a;
				else if (a == ST_X || b == ST_X) r = ST_X;
				else r = ST_1;
			end
			OP_WOR: begin
				if (a == ST_1 || b == ST_1) r = ST_1;
				else if (a == ST_Z) r = b;
				else if (b == ST_Z) r = a;
				else if (a == ST_X || b == ST_X) r = ST_X;
				else r = ST_0;
			end
			OP_STD: begin
				// codes past don't care resolve to X
				if (a < 4'(NUM_CODES) && b < 4'(NUM_CODES)) r = IEEE_TBL[a][b];
				else r = ST_X;
			end
			default: r = a;
		endcase
		return r;
	endfunction

	function automatic logic lane_mismatch(op_t op, state_t a, state_t b);
		logic skip_z;
		logic skip_x;
		skip_z = (op == OP_MATCH_XZ) && (a == ST_Z || b == ST_Z);
		skip_x = (op != OP_EQUAL) && (a == ST_X || b == ST_X);
		return !skip_z && !skip_x && (a != b);
	endfunction

endpackage

>>> src/multivalue_logic_vector_resolver.sv
// Resolves or compares two vectors of nine-value logic lanes (4-bit codes 0 1 X Z U W L H -).
// Opcodes 0 to 3 resolve lane by lane over the smaller width (plain, wired-and, wired-or,
// standard nine-value table) and copy vector a above it; opcodes 4 to 6 compare without
// strength and give is_match, with states_out zero. A three-stage pipeline (width decode,
// lane cells, output reduce) takes one request per clock while out_ready stays high and
// registers each result in every stage in turn; ready passes back combinationally through the
// stages, so a stalled output holds up to three requests in flight without loss.
`timescale 1ns / 1ps
module multivalue_logic_vector_resolver #(
	parameter int LANES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   opcode,
	input  logic [4*LANES-1:0]           states_a,
	input  logic [4*LANES-1:0]           states_b,
	input  logic [mlvr_pkg::WIDTH_W-1:0] width_a,
	input  logic [mlvr_pkg::WIDTH_W-1:0] width_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [4*LANES-1:0]           states_out,
	output logic                         is_match
);

	logic               valid_s1;
	logic               ready_s2;
	mlvr_pkg::ctrl_t    ctrl_s1;
	logic [4*LANES-1:0] a_s1;
	logic [4*LANES-1:0] b_s1;
	logic [LANES-1:0]   rmask_s1;
	logic [LANES-1:0]   cmask_s1;
	logic               valid_s2;
	logic               ready_s3;
	mlvr_pkg::ctrl_t    ctrl_s2;
	logic [4*LANES-1:0] states_s2;
	logic [LANES-1:0]   mism_s2;

	mlvr_front #(.LANES(LANES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.states_a (states_a),
		.states_b (states_b),
		.width_a  (width_a),
		.width_b  (width_b),
		.valid_s1 (valid_s1),
		.ready_s2 (ready_s2),
		.ctrl_s1  (ctrl_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.rmask_s1 (rmask_s1),
		.cmask_s1 (cmask_s1)
	);

	mlvr_lanes #(.LANES(LANES)) u_lanes (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ready_s2  (ready_s2),
		.ctrl_s1   (ctrl_s1),
		.a_s1      (a_s1),
		.b_s1      (b_s1),
		.rmask_s1  (rmask_s1),
		.cmask_s1  (cmask_s1),
		.valid_s2  (valid_s2),
		.ready_s3  (ready_s3),
		.ctrl_s2   (ctrl_s2),
		.states_s2 (states_s2),
		.mism_s2   (mism_s2)
	);

	mlvr_back #(.LANES(LANES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.ready_s3   (ready_s3),
		.ctrl_s2    (ctrl_s2),
		.states_s2  (states_s2),
		.mism_s2    (mism_s2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.states_out (states_out),
		.is_match   (is_match)
	);

endmodule

>>> src/mlvr_front.sv
`timescale 1ns / 1ps
module mlvr_front #(
	parameter int LANES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  opcode,
	input  logic [4*LANES-1:0]          states_a,
	input  logic [4*LANES-1:0]          states_b,
	input  logic [mlvr_pkg::WIDTH_W-1:0] width_a,
	input  logic [mlvr_pkg::WIDTH_W-1:0] width_b,
	output logic                        valid_s1,
	input  logic                        ready_s2,
	output mlvr_pkg::ctrl_t             ctrl_s1,
	output logic [4*LANES-1:0]          a_s1,
	output logic [4*LANES-1:0]          b_s1,
	output logic [LANES-1:0]            rmask_s1,
	output logic [LANES-1:0]            cmask_s1
);

	localparam logic [mlvr_pkg::WIDTH_W-1:0] LANES_W = mlvr_pkg::WIDTH_W'(LANES);

	logic [mlvr_pkg::WIDTH_W-1:0] na;
	logic [mlvr_pkg::WIDTH_W-1:0] nb;
	logic [mlvr_pkg::WIDTH_W-1:0] nmin;
	logic [LANES-1:0]             rmask;
	logic [LANES-1:0]             cmask;
	mlvr_pkg::ctrl_t              ctrl;

	assign na   = (width_a > LANES_W) ? LANES_W : width_a;
	assign nb   = (width_b > LANES_W) ? LANES_W : width_b;
	assign nmin = (na < nb) ? na : nb;

	// the compare's width check uses the raw width fields
	assign ctrl.op       = mlvr_pkg::op_t'(opcode);
	assign ctrl.width_eq = (width_a == width_b);

	for (genvar i = 0; i < LANES; i++) begin : g_mask
		assign rmask[i] = mlvr_pkg::WIDTH_W'(i) < nmin;
		assign cmask[i] = mlvr_pkg::WIDTH_W'(i) < na;
	end

	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_s1  <= ctrl;
			a_s1     <= states_a;
			b_s1     <= states_b;
			rmask_s1 <= rmask;
			cmask_s1 <= cmask;
		end
	end

endmodule

>>> src/mlvr_lanes.sv
`timescale 1ns / 1ps
module mlvr_lanes #(
	parameter int LANES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	output logic               ready_s2,
	input  mlvr_pkg::ctrl_t    ctrl_s1,
	input  logic [4*LANES-1:0] a_s1,
	input  logic [4*LANES-1:0] b_s1,
	input  logic [LANES-1:0]   rmask_s1,
	input  logic [LANES-1:0]   cmask_s1,
	output logic               valid_s2,
	input  logic               ready_s3,
	output mlvr_pkg::ctrl_t    ctrl_s2,
	output logic [4*LANES-1:0] states_s2,
	output logic [LANES-1:0]   mism_s2
);

	logic [4*LANES-1:0] states;
	logic [LANES-1:0]   mism;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mlvr_pkg::state_t a;
		mlvr_pkg::state_t b;
		assign a = a_s1[4*i +: 4];
		assign b = b_s1[4*i +: 4];
		// lanes past the smaller width keep vector a
		assign states[4*i +: 4] = rmask_s1[i] ? mlvr_pkg::resolve_lane(ctrl_s1.op, a, b) : a;
		assign mism[i] = cmask_s1[i] && mlvr_pkg::lane_mismatch(ctrl_s1.op, a, b);
	end

	assign ready_s2 = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctrl_s2   <= ctrl_s1;
			states_s2 <= states;
			mism_s2   <= mism;
		end
	end

endmodule

>>> src/mlvr_back.sv
`timescale 1ns / 1ps
module mlvr_back #(
	parameter int LANES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	output logic               ready_s3,
	input  mlvr_pkg::ctrl_t    ctrl_s2,
	input  logic [4*LANES-1:0] states_s2,
	input  logic [LANES-1:0]   mism_s2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4*LANES-1:0] states_out,
	output logic               is_match
);

	logic               valid_s3;
	logic [4*LANES-1:0] states_s3;
	logic               match_s3;
	logic [4*LANES-1:0] states_nx;
	logic               match_nx;

	always_comb begin
		states_nx = '0;
		match_nx  = 1'b0;
		case (ctrl_s2.op)
			mlvr_pkg::OP_RESOLVE, mlvr_pkg::OP_WAND,
			mlvr_pkg::OP_WOR, mlvr_pkg::OP_STD: begin
				states_nx = states_s2;
			end
			mlvr_pkg::OP_EQUAL, mlvr_pkg::OP_MATCH_X, mlvr_pkg::OP_MATCH_XZ: begin
				match_nx = ctrl_s2.width_eq && !(|mism_s2);
			end
			default: begin
				states_nx = '0;
				match_nx  = 1'b0;
			end
		endcase
	end

	assign ready_s3 = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			states_s3 <= states_nx;
			match_s3  <= match_nx;
		end
	end

	assign out_valid  = valid_s3;
	assign states_out = states_s3;
	assign is_match   = match_s3;

endmodule

>>> src/mlvr_checker.sv
`timescale 1ns / 1ps
`include "multivalue_logic_vector_resolver_assert.svh"
module mlvr_checker #(
	parameter int LANES = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [2:0]                   opcode,
	input logic [4*LANES-1:0]           states_a,
	input logic [4*LANES-1:0]           states_b,
	input logic [mlvr_pkg::WIDTH_W-1:0] width_a,
	input logic [mlvr_pkg::WIDTH_W-1:0] width_b,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [4*LANES-1:0]           states_out,
	input logic                         is_match
);

	// a waiting request holds its payload
	`MLVR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(opcode) && $stable(states_a) && $stable(states_b)
		&& $stable(width_a) && $stable(width_b))

	// a stalled result holds
	`MLVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(states_out) && $stable(is_match))

	// a match only comes from a compare, which clears the states
	`MLVR_ASSERT_NOW(a_match_zero, out_valid && is_match, states_out == '0)

	// a free output never backs up the input side
	`MLVR_ASSERT_NOW(a_no_bubble, out_ready, in_ready)

	// an empty pipeline takes a request at once
	`MLVR_ASSERT_NEXT(a_drain_ready, !in_valid && !out_valid, in_ready)

endmodule

bind multivalue_logic_vector_resolver mlvr_checker #(.LANES(LANES)) u_mlvr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.opcode     (opcode),
	.states_a   (states_a),
	.states_b   (states_b),
	.width_a    (width_a),
	.width_b    (width_b),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.states_out (states_out),
	.is_match   (is_match)
);

>>> sim/multivalue_logic_vector_resolver_test.sv
`timescale 1ns / 1ps
module multivalue_logic_vector_resolver_test;

	localparam int LANES          = 16;
	localparam int HOLD_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 250;

	typedef struct packed {
		mlvr_pkg::op_t                      op;
		logic [4*LANES-1:0]                 a;
		logic [4*LANES-1:0]                 b;
		logic [mlvr_pkg::WIDTH_W-1:0]       wa;
		logic [mlvr_pkg::WIDTH_W-1:0]       wb;
	} request_t;

	typedef struct packed {
		logic [4*LANES-1:0] states;
		logic               match;
	} resolution_t;

	// nine-value resolution, rows driver a, columns driver b, code order 0 1 X Z U W L H -
	localparam mlvr_pkg::state_t STD_RESOLVE [0:8][0:8] = '{
		'{mlvr_pkg::ST_0, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_0, mlvr_pkg::ST_U,
			mlvr_pkg::ST_0, mlvr_pkg::ST_0, mlvr_pkg::ST_0, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_X, mlvr_pkg::ST_1, mlvr_pkg::ST_X, mlvr_pkg::ST_1, mlvr_pkg::ST_U,
			mlvr_pkg::ST_1, mlvr_pkg::ST_1, mlvr_pkg::ST_1, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_U,
			mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_0, mlvr_pkg::ST_1, mlvr_pkg::ST_X, mlvr_pkg::ST_Z, mlvr_pkg::ST_U,
			mlvr_pkg::ST_W, mlvr_pkg::ST_L, mlvr_pkg::ST_H, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_U, mlvr_pkg::ST_U, mlvr_pkg::ST_U, mlvr_pkg::ST_U, mlvr_pkg::ST_U,
			mlvr_pkg::ST_U, mlvr_pkg::ST_U, mlvr_pkg::ST_U, mlvr_pkg::ST_U},
		'{mlvr_pkg::ST_0, mlvr_pkg::ST_1, mlvr_pkg::ST_X, mlvr_pkg::ST_W, mlvr_pkg::ST_U,
			mlvr_pkg::ST_W, mlvr_pkg::ST_W, mlvr_pkg::ST_W, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_0, mlvr_pkg::ST_1, mlvr_pkg::ST_X, mlvr_pkg::ST_L, mlvr_pkg::ST_U,
			mlvr_pkg::ST_W, mlvr_pkg::ST_L, mlvr_pkg::ST_W, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_0, mlvr_pkg::ST_1, mlvr_pkg::ST_X, mlvr_pkg::ST_H, mlvr_pkg::ST_U,
			mlvr_pkg::ST_W, mlvr_pkg::ST_W, mlvr_pkg::ST_H, mlvr_pkg::ST_X},
		'{mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_U,
			mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X, mlvr_pkg::ST_X}
	};

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [2:0]                   opcode     = mlvr_pkg::OP_RESOLVE;
	logic [4*LANES-1:0]           states_a   = '0;
	logic [4*LANES-1:0]           states_b   = '0;
	logic [mlvr_pkg::WIDTH_W-1:0] width_a    = '0;
	logic [mlvr_pkg::WIDTH_W-1:0] width_b    = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [4*LANES-1:0]           states_out;
	logic                         is_match;

	request_t    request_queue [$];
	resolution_t awaited_results [$];
	request_t    on_bus;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_req      = 1'b0;
	int          hold_cnt;
	int          quiet_cycles;
	int          errors        = 0;

	multivalue_logic_vector_resolver #(
		.LANES(LANES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.states_a  (states_a),
		.states_b  (states_b),
		.width_a   (width_a),
		.width_b   (width_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.states_out(states_out),
		.is_match  (is_match)
	);

	always #4 clk = ~clk;

	function automatic mlvr_pkg::state_t lane_outcome(mlvr_pkg::op_t op, mlvr_pkg::state_t a,
		mlvr_pkg::state_t b);
		mlvr_pkg::state_t r;
		case (op)
			mlvr_pkg::OP_RESOLVE: begin
				if (a == b) r = a;
				else if (a == mlvr_pkg::ST_Z) r = b;
				else if (b == mlvr_pkg::ST_Z) r = a;
				else r = mlvr_pkg::ST_X;
			end
			mlvr_pkg::OP_WAND: begin
				if (a == mlvr_pkg::ST_0 || b == mlvr_pkg::ST_0) r = mlvr_pkg::ST_0;
				else if (a == mlvr_pkg::ST_Z) r = b;
				else if (b == mlvr_pkg::ST_Z) r = a;
				else if (a == mlvr_pkg::ST_X || b == mlvr_pkg::ST_X) r = mlvr_pkg::ST_X;
				else r = mlvr_pkg::ST_1;
			end
			mlvr_pkg::OP_WOR: begin
				if (a == mlvr_pkg::ST_1 || b == mlvr_pkg::ST_1) r = mlvr_pkg::ST_1;
				else if (a == mlvr_pkg::ST_Z) r = b;
				else if (b == mlvr_pkg::ST_Z) r = a;
				else if (a == mlvr_pkg::ST_X || b == mlvr_pkg::ST_X) r = mlvr_pkg::ST_X;
				else r = mlvr_pkg::ST_0;
			end
			default: begin
				// codes past don't care give X
				if (a <= mlvr_pkg::ST_DC && b <= mlvr_pkg::ST_DC) r = STD_RESOLVE[a][b];
				else r = mlvr_pkg::ST_X;
			end
		endcase
		return r;
	endfunction

	function automatic logic lanes_agree(mlvr_pkg::op_t op, mlvr_pkg::state_t a,
		mlvr_pkg::state_t b);
		if (op == mlvr_pkg::OP_MATCH_XZ && (a == mlvr_pkg::ST_Z || b == mlvr_pkg::ST_Z))
			return 1'b1;
		if (op != mlvr_pkg::OP_EQUAL && (a == mlvr_pkg::ST_X || b == mlvr_pkg::ST_X))
			return 1'b1;
		return a == b;
	endfunction

	function automatic resolution_t resolve_vectors(request_t rq);
		resolution_t r;
		int          na;
		int          nb;
		logic        ok;
		r.states = '0;
		r.match  = 1'b0;
		na = (rq.wa > LANES) ? LANES : int'(rq.wa);
		nb = (rq.wb > LANES) ? LANES : int'(rq.wb);
		case (rq.op)
			mlvr_pkg::OP_RESOLVE, mlvr_pkg::OP_WAND, mlvr_pkg::OP_WOR, mlvr_pkg::OP_STD: begin
				r.states = rq.a;
				for (int i = 0; i < LANES; i++)
					if (i < na && i < nb)
						r.states[4*i +: 4] = lane_outcome(rq.op, rq.a[4*i +: 4], rq.b[4*i +: 4]);
			end
			mlvr_pkg::OP_EQUAL, mlvr_pkg::OP_MATCH_X, mlvr_pkg::OP_MATCH_XZ: begin
				// raw widths must agree, lanes only up to the saturated width
				ok = (rq.wa == rq.wb);
				for (int i = 0; i < LANES; i++)
					if (i < na && !lanes_agree(rq.op, rq.a[4*i +: 4], rq.b[4*i +: 4]))
						ok = 1'b0;
				r.match = ok;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [4*LANES-1:0] random_lanes();
		logic [4*LANES-1:0] v;
		if ($urandom_range(9) == 0) return {$urandom, $urandom};
		for (int i = 0; i < LANES; i++)
			v[4*i +: 4] = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
		return v;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int       mode;
		rq.op = mlvr_pkg::op_t'($urandom_range(6));
		rq.a  = random_lanes();
		rq.b  = random_lanes();
		rq.wa = mlvr_pkg::WIDTH_W'($urandom_range(LANES));
		rq.wb = mlvr_pkg::WIDTH_W'($urandom_range(LANES));
		if (rq.op >= mlvr_pkg::OP_EQUAL) begin
			// compares mostly on equal widths with b close to a, so matches happen
			if ($urandom_range(3) != 0) rq.wb = rq.wa;
			mode = $urandom_range(3);
			if (mode != 0) begin
				rq.b = rq.a;
				if (mode >= 2)
					for (int i = 0; i < LANES; i++)
						case ($urandom_range(23))
							0: rq.b[4*i +: 4] = mlvr_pkg::ST_X;
							1: rq.a[4*i +: 4] = mlvr_pkg::ST_X;
							2: rq.b[4*i +: 4] = mlvr_pkg::ST_Z;
							3: rq.a[4*i +: 4] = mlvr_pkg::ST_Z;
							4: rq.b[4*i +: 4] = 4'($urandom_range(15));
							default: ;
						endcase
			end
		end
		return rq;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(resolve_vectors(on_bus));
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = request_queue.pop_front();
					opcode   <= on_bus.op;
					states_a <= on_bus.a;
					states_b <= on_bus.b;
					width_a  <= on_bus.wa;
					width_b  <= on_bus.wb;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		resolution_t oldest;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, states_out %h is_match %b",
						$time, states_out, is_match);
				end else begin
					oldest = awaited_results.pop_front();
					if (states_out !== oldest.states) begin
						errors++;
						$display("%0t: states_out expected %h actual %h",
							$time, oldest.states, states_out);
					end
					if (is_match !== oldest.match) begin
						errors++;
						$display("%0t: is_match expected %b actual %b",
							$time, oldest.match, is_match);
					end
				end
			end
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				hold_cnt  <= hold_cnt + 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [4*LANES-1:0] va;
		logic [4*LANES-1:0] vb;
		int                 pair;

		send_idle_pct = 37;
		recv_idle_pct = 74;

		// every nine-value table pair, up to sixteen per request
		for (int k = 0; k < 6; k++) begin
			va = '0;
			vb = '0;
			for (int l = 0; l < LANES; l++) begin
				pair = k * LANES + l;
				if (pair < 81) begin
					va[4*l +: 4] = 4'(pair / 9);
					vb[4*l +: 4] = 4'(pair % 9);
				end
			end
			request_queue.push_back('{mlvr_pkg::OP_STD, va, vb, 5'd16, 5'd16});
		end
		request_queue.push_back('{mlvr_pkg::OP_RESOLVE, random_lanes(), random_lanes(),
			5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WAND, random_lanes(), random_lanes(),
			5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WOR, random_lanes(), random_lanes(),
			5'd16, 5'd16});

		// codes above don't care in every resolve mode
		va = 64'hFEDCBA9876543210;
		vb = 64'h0123456789ABCDEF;
		request_queue.push_back('{mlvr_pkg::OP_STD, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_RESOLVE, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WAND, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WOR, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WOR, '1, '0, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_WAND, '0, '1, 5'd16, 5'd16});

		// empty b leaves a untouched
		request_queue.push_back('{mlvr_pkg::OP_RESOLVE, random_lanes(), random_lanes(),
			5'd16, 5'd0});

		va = random_lanes();
		request_queue.push_back('{mlvr_pkg::OP_EQUAL, va, va, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_EQUAL, va, va, 5'd16, 5'd15});
		vb = va;
		vb[15:12] = mlvr_pkg::ST_X;
		request_queue.push_back('{mlvr_pkg::OP_MATCH_X, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_EQUAL, va, vb, 5'd16, 5'd16});
		vb = va;
		vb[7:4] = mlvr_pkg::ST_Z;
		vb[3:0] = mlvr_pkg::ST_X;
		request_queue.push_back('{mlvr_pkg::OP_MATCH_XZ, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_MATCH_X, va, vb, 5'd16, 5'd16});
		request_queue.push_back('{mlvr_pkg::OP_EQUAL, random_lanes(), random_lanes(),
			5'd0, 5'd0});
		request_queue.push_back('{mlvr_pkg::OP_MATCH_XZ, '1, '0, 5'd0, 5'd0});

		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			request_queue.push_back(random_request());

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// sender pauses until all results are back
		while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		send_idle_pct = 74;
		recv_idle_pct = 37;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			request_queue.push_back(random_request());

		while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// long output stall while requests keep coming, so the pipe backs up
		hold_req = 1'b1;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			request_queue.push_back(random_request());

		while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/mlvr_pkg.sv
src/mlvr_front.sv
src/mlvr_lanes.sv
src/mlvr_back.sv
src/multivalue_logic_vector_resolver.sv
src/mlvr_checker.sv
sim/multivalue_logic_vector_resolver_test.sv
